/* sv/rv64dec_pkg.sv */
// Shared constants for the RV64IM decode stage: encodings, operation codes and register-file size.
package rv64dec_pkg;

   localparam int NUM_REGS  = 32;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   localparam int XLEN   = 64;
   localparam int PC_W   = 62;
   localparam int INSN_W = 32;
   localparam int REG_W  = 5;

   // Item kinds on the request channel
   localparam logic KIND_DECODE = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   // Major opcodes
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_32  = 7'h3B;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_IMM_32 = 7'h1B;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct7 groups
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [5:0] F6_SRA    = 6'h10;

   // funct3 values
   localparam logic [2:0] F3_0 = 3'd0;
   localparam logic [2:0] F3_1 = 3'd1;
   localparam logic [2:0] F3_2 = 3'd2;
   localparam logic [2:0] F3_3 = 3'd3;
   localparam logic [2:0] F3_4 = 3'd4;
   localparam logic [2:0] F3_5 = 3'd5;
   localparam logic [2:0] F3_6 = 3'd6;
   localparam logic [2:0] F3_7 = 3'd7;

   localparam logic [11:0] IMM_ECALL  = 12'd0;
   localparam logic [11:0] IMM_EBREAK = 12'd1;

   localparam logic [REG_W-1:0] ECALL_A_REG = 5'd10;
   localparam logic [REG_W-1:0] ECALL_B_REG = 5'd11;

   // ALU codes
   localparam logic [4:0] EXE_NONE   = 5'd0;
   localparam logic [4:0] EXE_ADD    = 5'd1;
   localparam logic [4:0] EXE_MUL    = 5'd2;
   localparam logic [4:0] EXE_SUB    = 5'd3;
   localparam logic [4:0] EXE_SLL    = 5'd4;
   localparam logic [4:0] EXE_MULH   = 5'd5;
   localparam logic [4:0] EXE_MULHSU = 5'd6;
   localparam logic [4:0] EXE_MULHU  = 5'd7;
   localparam logic [4:0] EXE_SLT    = 5'd8;
   localparam logic [4:0] EXE_SLTU   = 5'd9;
   localparam logic [4:0] EXE_XOR    = 5'd10;
   localparam logic [4:0] EXE_DIV    = 5'd11;
   localparam logic [4:0] EXE_DIVU   = 5'd12;
   localparam logic [4:0] EXE_SRL    = 5'd13;
   localparam logic [4:0] EXE_SRA    = 5'd14;
   localparam logic [4:0] EXE_OR     = 5'd15;
   localparam logic [4:0] EXE_REM    = 5'd16;
   localparam logic [4:0] EXE_REMU   = 5'd17;
   localparam logic [4:0] EXE_AND    = 5'd18;
   localparam logic [4:0] EXE_ADDW   = 5'd19;
   localparam logic [4:0] EXE_SUBW   = 5'd20;
   localparam logic [4:0] EXE_SLLW   = 5'd21;
   localparam logic [4:0] EXE_SRLW   = 5'd22;
   localparam logic [4:0] EXE_SRAW   = 5'd23;
   localparam logic [4:0] EXE_MULW   = 5'd24;
   localparam logic [4:0] EXE_DIVW   = 5'd25;
   localparam logic [4:0] EXE_REMW   = 5'd26;
   localparam logic [4:0] EXE_REMUW  = 5'd27;

   // Branch codes
   localparam logic [3:0] BR_NONE = 4'd0;
   localparam logic [3:0] BR_BEQ  = 4'd1;
   localparam logic [3:0] BR_BNE  = 4'd2;
   localparam logic [3:0] BR_BLT  = 4'd3;
   localparam logic [3:0] BR_BGE  = 4'd4;
   localparam logic [3:0] BR_BLTU = 4'd5;
   localparam logic [3:0] BR_BGEU = 4'd6;
   localparam logic [3:0] BR_JAL  = 4'd7;
   localparam logic [3:0] BR_JALR = 4'd8;

   // Memory codes: loads from MEM_LOAD_BASE, stores from MEM_STORE_BASE
   localparam logic [3:0] MEM_NONE       = 4'd0;
   localparam logic [3:0] MEM_LOAD_BASE  = 4'd1;
   localparam logic [3:0] MEM_STORE_BASE = 4'd8;

   // Status codes
   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_ECALL   = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

endpackage

/* sv/rv64im_instruction_decode.sv */
// RV64IM decode stage with its register file, input stage and registered result.
//
// Request channel (req_*): a word is either a decode (req_kind low) carrying an
// instruction and a word-indexed PC, or a register write (req_kind high) that
// loads req_write_value into entry req_write_index. Writes to entry zero are
// dropped, so it always reads zero. A write yields no result word.
// Result channel (rsp_*): one word per decode, in request order.
// A decode is registered in the input stage at its accept edge and then in the result register.
// Throughput: one word per cycle while req_stall is low. The register file has two
// read ports sampled at the accept edge, followed by one decode stage and the result
// register; a write accepted at one edge is seen by a decode accepted at the next.
// Stall: while rsp_stall holds a result, the decode stage fills behind it and
// req_stall rises only once both stages are occupied.
// Reset: clears the valid flags of both stages and all register-file entry
// flags; every entry then reads zero until written.
module rv64im_instruction_decode
   import rv64dec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [INSN_W-1:0]   req_instruction,
   input  logic [PC_W-1:0]     req_pc,
   input  logic [REG_W-1:0]    req_write_index,
   input  logic [XLEN-1:0]     req_write_value,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [REG_W-1:0]    rsp_dest_reg,
   output logic                rsp_reg_write,
   output logic [4:0]          rsp_alu_op,
   output logic [3:0]          rsp_branch_op,
   output logic [3:0]          rsp_mem_op,
   output logic [XLEN-1:0]     rsp_operand_a,
   output logic [XLEN-1:0]     rsp_operand_b,
   output logic [XLEN-1:0]     rsp_result_value,
   output logic [XLEN-1:0]     rsp_store_data,
   output logic [PC_W-1:0]     rsp_next_pc,
   output logic [1:0]          rsp_status,
   output logic [11:0]         rsp_source_regs
);

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s2_free;
   logic req_accept;
   logic dec_accept;
   logic wr_accept;

   assign s2_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s2_free;
   assign req_accept = req_valid && !req_stall;
   assign dec_accept = req_accept && (req_kind == KIND_DECODE);
   assign wr_accept  = req_accept && (req_kind == KIND_WRITE);

   // ---------------------------------------------------------------- register file
   logic [XLEN-1:0] rf_ff [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic wr_in_range;
   logic wr_enable;

   assign wr_in_range = ({1'b0, req_write_index} < (REG_W + 1)'(NUM_REGS));
   assign wr_enable   = wr_accept && wr_in_range && (req_write_index != '0);

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         rf_ff[req_write_index[REG_IDX_W-1:0]] <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (wr_enable) begin
         rf_valid_ff[req_write_index[REG_IDX_W-1:0]] <= 1'b1;
      end
   end

   // ecall reads a0/a1 instead of the rs fields
   logic            req_is_ecall;
   logic [REG_W-1:0] rd_addr_a;
   logic [REG_W-1:0] rd_addr_b;
   logic            rd_range_a;
   logic            rd_range_b;

   assign req_is_ecall = (req_instruction[6:0] == OPC_SYSTEM)
                      && (req_instruction[14:12] == F3_0)
                      && (req_instruction[31:20] == IMM_ECALL);
   assign rd_addr_a  = req_is_ecall ? ECALL_A_REG : req_instruction[19:15];
   assign rd_addr_b  = req_is_ecall ? ECALL_B_REG : req_instruction[24:20];
   assign rd_range_a = ({1'b0, rd_addr_a} < (REG_W + 1)'(NUM_REGS));
   assign rd_range_b = ({1'b0, rd_addr_b} < (REG_W + 1)'(NUM_REGS));

   // ---------------------------------------------------------------- stage 1
   logic [INSN_W-1:0] s1_ins_ff;
   logic [PC_W-1:0]   s1_pc_ff;
   logic [XLEN-1:0]   s1_ra_ff;
   logic [XLEN-1:0]   s1_rb_ff;
   logic              s1_ra_ok_ff;
   logic              s1_rb_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= dec_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_accept) begin
         s1_ins_ff   <= req_instruction;
         s1_pc_ff    <= req_pc;
         s1_ra_ff    <= rf_ff[rd_addr_a[REG_IDX_W-1:0]];
         s1_rb_ff    <= rf_ff[rd_addr_b[REG_IDX_W-1:0]];
         s1_ra_ok_ff <= rd_range_a && rf_valid_ff[rd_addr_a[REG_IDX_W-1:0]];
         s1_rb_ok_ff <= rd_range_b && rf_valid_ff[rd_addr_b[REG_IDX_W-1:0]];
      end
   end

   // ---------------------------------------------------------------- decode
   logic [6:0]       opc;
   logic [REG_W-1:0] rd;
   logic [2:0]       f3;
   logic [REG_W-1:0] r1;
   logic [REG_W-1:0] r2;
   logic [6:0]       f7;
   logic [XLEN-1:0]  ra;
   logic [XLEN-1:0]  rb;
   logic [XLEN-1:0]  imm_i;
   logic [XLEN-1:0]  imm_s;
   logic [XLEN-1:0]  imm_u;
   logic [PC_W-1:0]  br_target;
   logic [PC_W-1:0]  jal_target;
   logic [XLEN-1:0]  jalr_sum;
   logic [XLEN-1:0]  link_addr;
   logic [XLEN-1:0]  auipc_val;

   assign opc = s1_ins_ff[6:0];
   assign rd  = s1_ins_ff[11:7];
   assign f3  = s1_ins_ff[14:12];
   assign r1  = s1_ins_ff[19:15];
   assign r2  = s1_ins_ff[24:20];
   assign f7  = s1_ins_ff[31:25];
   assign ra  = s1_ra_ok_ff ? s1_ra_ff : '0;
   assign rb  = s1_rb_ok_ff ? s1_rb_ff : '0;

   assign imm_i = {{52{s1_ins_ff[31]}}, s1_ins_ff[31:20]};
   assign imm_s = {{52{s1_ins_ff[31]}}, s1_ins_ff[31:25], s1_ins_ff[11:7]};
   assign imm_u = {{32{s1_ins_ff[31]}}, s1_ins_ff[31:12], 12'b0};

   // branch and jal offsets are already in words
   assign br_target  = s1_pc_ff + {{51{s1_ins_ff[31]}}, s1_ins_ff[31], s1_ins_ff[7],
                                   s1_ins_ff[30:25], s1_ins_ff[11:9]};
   assign jal_target = s1_pc_ff + {{43{s1_ins_ff[31]}}, s1_ins_ff[31], s1_ins_ff[19:12],
                                   s1_ins_ff[20], s1_ins_ff[30:22]};
   assign jalr_sum   = ra + imm_i;
   assign link_addr  = {s1_pc_ff + PC_W'(1), 2'b00};
   assign auipc_val  = {s1_pc_ff, 2'b00} + imm_u;

   logic             wr_in;
   logic [4:0]       alu_in;
   logic [3:0]       br_in;
   logic [3:0]       mem_in;
   logic [1:0]       st_in;
   logic [XLEN-1:0]  a_in;
   logic [XLEN-1:0]  b_in;
   logic [XLEN-1:0]  res_in;
   logic [XLEN-1:0]  sd_in;
   logic [PC_W-1:0]  npc_in;
   logic [REG_W-1:0] s1n_in;
   logic [REG_W-1:0] s2n_in;
   logic             u1_in;
   logic             u2_in;

   always_comb begin
      wr_in  = 1'b0;
      alu_in = EXE_NONE;
      br_in  = BR_NONE;
      mem_in = MEM_NONE;
      st_in  = ST_NORMAL;
      a_in   = '0;
      b_in   = '0;
      res_in = '0;
      sd_in  = '0;
      npc_in = '0;
      s1n_in = '0;
      s2n_in = '0;
      u1_in  = 1'b0;
      u2_in  = 1'b0;

      case (opc)
         OPC_OP, OPC_OP_32: begin
            s1n_in = r1; s2n_in = r2; u1_in = 1'b1; u2_in = 1'b1;
            a_in = ra; b_in = rb; wr_in = 1'b1;
            if (opc == OPC_OP) begin
               case ({f7, f3})
                  {F7_BASE, F3_0}:   alu_in = EXE_ADD;
                  {F7_MULDIV, F3_0}: alu_in = EXE_MUL;
                  {F7_ALT, F3_0}:    alu_in = EXE_SUB;
                  {F7_BASE, F3_1}:   alu_in = EXE_SLL;
                  {F7_MULDIV, F3_1}: alu_in = EXE_MULH;
                  {F7_MULDIV, F3_2}: alu_in = EXE_MULHSU;
                  {F7_MULDIV, F3_3}: alu_in = EXE_MULHU;
                  {F7_BASE, F3_2}:   alu_in = EXE_SLT;
                  {F7_BASE, F3_3}:   alu_in = EXE_SLTU;
                  {F7_BASE, F3_4}:   alu_in = EXE_XOR;
                  {F7_MULDIV, F3_4}: alu_in = EXE_DIV;
                  {F7_MULDIV, F3_5}: alu_in = EXE_DIVU;
                  {F7_BASE, F3_5}:   alu_in = EXE_SRL;
                  {F7_ALT, F3_5}:    alu_in = EXE_SRA;
                  {F7_BASE, F3_6}:   alu_in = EXE_OR;
                  {F7_MULDIV, F3_6}: alu_in = EXE_REM;
                  {F7_MULDIV, F3_7}: alu_in = EXE_REMU;
                  {F7_BASE, F3_7}:   alu_in = EXE_AND;
                  default:           alu_in = EXE_NONE;
               endcase
            end else begin
               case ({f7, f3})
                  {F7_BASE, F3_0}:   alu_in = EXE_ADDW;
                  {F7_ALT, F3_0}:    alu_in = EXE_SUBW;
                  {F7_BASE, F3_1}:   alu_in = EXE_SLLW;
                  {F7_BASE, F3_5}:   alu_in = EXE_SRLW;
                  {F7_ALT, F3_5}:    alu_in = EXE_SRAW;
                  {F7_MULDIV, F3_0}: alu_in = EXE_MULW;
                  {F7_MULDIV, F3_4}: alu_in = EXE_DIVW;
                  {F7_MULDIV, F3_6}: alu_in = EXE_REMW;
                  {F7_MULDIV, F3_7}: alu_in = EXE_REMUW;
                  default:           alu_in = EXE_NONE;
               endcase
            end
            if (alu_in == EXE_NONE) st_in = ST_ILLEGAL;
         end
         OPC_OP_IMM: begin
            s1n_in = r1; u1_in = 1'b1; a_in = ra; wr_in = 1'b1;
            if (f3 inside {F3_1, F3_5}) begin
               b_in = {58'b0, s1_ins_ff[25:20]};
               if (s1_ins_ff[31:26] == 6'b0) begin
                  alu_in = (f3 == F3_1) ? EXE_SLL : EXE_SRL;
               end else if (f3 == F3_5 && s1_ins_ff[31:26] == F6_SRA) begin
                  alu_in = EXE_SRA;
               end else begin
                  st_in = ST_ILLEGAL;
                  b_in  = '0;
               end
            end else begin
               b_in = imm_i;
               case (f3)
                  F3_0:    alu_in = EXE_ADD;
                  F3_2:    alu_in = EXE_SLT;
                  F3_3:    alu_in = EXE_SLTU;
                  F3_4:    alu_in = EXE_XOR;
                  F3_6:    alu_in = EXE_OR;
                  F3_7:    alu_in = EXE_AND;
                  default: alu_in = EXE_NONE;
               endcase
            end
         end
         OPC_IMM_32: begin
            s1n_in = r1; u1_in = 1'b1; a_in = ra; wr_in = 1'b1;
            if (f3 == F3_0) begin
               alu_in = EXE_ADDW; b_in = imm_i;
            end else if (f3 == F3_1 && f7 == F7_BASE) begin
               alu_in = EXE_SLLW; b_in = {59'b0, r2};
            end else if (f3 == F3_5 && f7 == F7_BASE) begin
               alu_in = EXE_SRLW; b_in = {59'b0, r2};
            end else if (f3 == F3_5 && f7 == F7_ALT) begin
               alu_in = EXE_SRAW; b_in = {59'b0, r2};
            end else begin
               st_in = ST_ILLEGAL;
            end
         end
         OPC_LOAD: begin
            s1n_in = r1; u1_in = 1'b1; alu_in = EXE_ADD; wr_in = 1'b1;
            a_in = ra; b_in = imm_i;
            if (f3 == F3_7) st_in = ST_ILLEGAL;
            else            mem_in = MEM_LOAD_BASE + {1'b0, f3};
         end
         OPC_STORE: begin
            s1n_in = r1; s2n_in = r2; u1_in = 1'b1; u2_in = 1'b1; alu_in = EXE_ADD;
            a_in = ra; b_in = imm_s; sd_in = rb;
            if (f3 > F3_3) st_in = ST_ILLEGAL;
            else           mem_in = MEM_STORE_BASE + {1'b0, f3};
         end
         OPC_BRANCH: begin
            s1n_in = r1; s2n_in = r2; u1_in = 1'b1; u2_in = 1'b1;
            a_in = ra; b_in = rb; npc_in = br_target;
            case (f3)
               F3_0:    br_in = BR_BEQ;
               F3_1:    br_in = BR_BNE;
               F3_4:    br_in = BR_BLT;
               F3_5:    br_in = BR_BGE;
               F3_6:    br_in = BR_BLTU;
               F3_7:    br_in = BR_BGEU;
               default: br_in = BR_NONE;
            endcase
            if (br_in == BR_NONE) st_in = ST_ILLEGAL;
         end
         OPC_JAL: begin
            npc_in = jal_target; br_in = BR_JAL; wr_in = 1'b1; res_in = link_addr;
         end
         OPC_JALR: begin
            s1n_in = r1; u1_in = 1'b1;
            if (f3 != F3_0) begin
               st_in = ST_ILLEGAL;
            end else begin
               npc_in = jalr_sum[XLEN-1:2];
               br_in  = BR_JALR; wr_in = 1'b1; res_in = link_addr;
            end
         end
         OPC_AUIPC: begin
            wr_in = 1'b1; res_in = auipc_val;
         end
         OPC_LUI: begin
            wr_in = 1'b1; res_in = imm_u;
         end
         OPC_SYSTEM: begin
            // ebreak and csr forms fall through as no-ops
            if (f3 == F3_0) begin
               if (s1_ins_ff[31:20] == IMM_ECALL) begin
                  s1n_in = ECALL_A_REG; s2n_in = ECALL_B_REG;
                  u1_in = 1'b1; u2_in = 1'b1;
                  a_in = ra; b_in = rb; st_in = ST_ECALL;
               end else if (s1_ins_ff[31:20] != IMM_EBREAK) begin
                  st_in = ST_ILLEGAL;
               end
            end else if (f3 == F3_4) begin
               st_in = ST_ILLEGAL;
            end
         end
         default: st_in = ST_ILLEGAL;
      endcase
   end

   // ---------------------------------------------------------------- result register
   logic [REG_W-1:0] rsp_dest_reg_ff;
   logic             rsp_reg_write_ff;
   logic [4:0]       rsp_alu_op_ff;
   logic [3:0]       rsp_branch_op_ff;
   logic [3:0]       rsp_mem_op_ff;
   logic [XLEN-1:0]  rsp_operand_a_ff;
   logic [XLEN-1:0]  rsp_operand_b_ff;
   logic [XLEN-1:0]  rsp_result_value_ff;
   logic [XLEN-1:0]  rsp_store_data_ff;
   logic [PC_W-1:0]  rsp_next_pc_ff;
   logic [1:0]       rsp_status_ff;
   logic [11:0]      rsp_source_regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_free) begin
         rsp_dest_reg_ff     <= rd;
         rsp_reg_write_ff    <= wr_in;
         rsp_alu_op_ff       <= alu_in;
         rsp_branch_op_ff    <= br_in;
         rsp_mem_op_ff       <= mem_in;
         rsp_operand_a_ff    <= a_in;
         rsp_operand_b_ff    <= b_in;
         rsp_result_value_ff <= res_in;
         rsp_store_data_ff   <= sd_in;
         rsp_next_pc_ff      <= npc_in;
         rsp_status_ff       <= st_in;
         rsp_source_regs_ff  <= {u2_in, u1_in, s2n_in, s1n_in};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_reg     = rsp_dest_reg_ff;
   assign rsp_reg_write    = rsp_reg_write_ff;
   assign rsp_alu_op       = rsp_alu_op_ff;
   assign rsp_branch_op    = rsp_branch_op_ff;
   assign rsp_mem_op       = rsp_mem_op_ff;
   assign rsp_operand_a    = rsp_operand_a_ff;
   assign rsp_operand_b    = rsp_operand_b_ff;
   assign rsp_result_value = rsp_result_value_ff;
   assign rsp_store_data   = rsp_store_data_ff;
   assign rsp_next_pc      = rsp_next_pc_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_source_regs  = rsp_source_regs_ff;

   // ---------------------------------------------------------------- assertions
   // entry zero never becomes readable
   a_reg_zero: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("register zero marked as written");

   // a decode blocked by a stalled result stays in the decode stage
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff)
      else $error("decode word lost behind a stalled result");

   a_ecall_srcs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ECALL |->
         rsp_source_regs == {1'b1, 1'b1, ECALL_B_REG, ECALL_A_REG})
      else $error("ecall word without a0/a1 sources");

   a_mem_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_op != MEM_NONE |-> rsp_alu_op == EXE_ADD)
      else $error("memory access without address add");

   a_jal_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_op == BR_JAL |-> rsp_reg_write && rsp_source_regs == '0)
      else $error("jal word with wrong write enable or sources");

endmodule
